// ----- sv/pjrb_pkg.sv -----
// Package: shared constants, command and status codes, queue entry type.
package pjrb_pkg;
  localparam int unsigned CAPACITY_DEF = 8;
  localparam logic [16:0] LATE_WINDOW = 17'd32768;
  localparam logic [15:0] EXP_RESET = 16'd1;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_SET_GET = 2'd2;
  // unused encoding, behaves as a plain get
  localparam logic [1:0] CMD_GET_ALT = 2'd3;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_LATE = 3'd2;
  localparam logic [2:0] ST_DUP = 3'd3;
  localparam logic [2:0] ST_DELIVERED = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;
  localparam logic [2:0] ST_OOS = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] seq;
    logic [15:0] length;
    logic [31:0] handle;
  } cmd_t;
endpackage

// ----- sv/pjrb_front.sv -----
// Front end: accepts commands and buffers them in a two-entry queue.
module pjrb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pjrb_pkg::cmd_t  in_cmd_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output pjrb_pkg::cmd_t  q_cmd_o
);
  pjrb_pkg::cmd_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end
endmodule

// ----- sv/pjrb_back.sv -----
// Back end: sorted slot store, serial insertion walk, head pop, result register.
module pjrb_back #(
  parameter int unsigned CAPACITY = pjrb_pkg::CAPACITY_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  pjrb_pkg::cmd_t  q_cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      status_o,
  output logic [15:0]     length_o,
  output logic [31:0]     handle_o,
  output logic [3:0]      fill_o
);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_SHIFT} state_e;
  state_e state_q;

  logic [15:0] sseq_q [CAPACITY];
  logic [15:0] slen_q [CAPACITY];
  logic [31:0] shdl_q [CAPACITY];
  logic [CW-1:0] cnt_q, k_q;
  logic [15:0] exp_q;
  pjrb_pkg::cmd_t cur_q;
  logic ov_q;
  logic [2:0] st_q;
  logic [15:0] ol_q;
  logic [31:0] oh_q;

  logic [15:0] want, held, diff;
  logic [CW-1:0] km1;
  logic late;

  assign q_ready_o = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign length_o = ol_q;
  assign handle_o = oh_q;
  assign fill_o = 4'(cnt_q);

  assign want = (q_cmd_i.cmd == pjrb_pkg::CMD_SET_GET) ? q_cmd_i.seq : exp_q;
  assign diff = exp_q - q_cmd_i.seq;
  assign late = (q_cmd_i.seq < exp_q) && ({1'b0, diff} <= pjrb_pkg::LATE_WINDOW);
  assign km1 = k_q - CW'(1);
  assign held = sseq_q[km1[IW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      k_q <= '0;
      exp_q <= pjrb_pkg::EXP_RESET;
      ov_q <= 1'b0;
      st_q <= pjrb_pkg::ST_ADDED;
      ol_q <= '0;
      oh_q <= '0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i && q_ready_o) begin
            cur_q <= q_cmd_i;
            ol_q <= '0;
            oh_q <= '0;
            if (q_cmd_i.cmd == pjrb_pkg::CMD_ADD) begin
              if (cnt_q >= CW'(CAPACITY)) begin
                st_q <= pjrb_pkg::ST_FULL; ov_q <= 1'b1;
              end else if (late) begin
                st_q <= pjrb_pkg::ST_LATE; ov_q <= 1'b1;
              end else begin
                k_q <= cnt_q;
                state_q <= S_WALK;
              end
            end else begin
              exp_q <= want + 16'd1;
              if (cnt_q == '0) begin
                st_q <= pjrb_pkg::ST_EMPTY; ov_q <= 1'b1;
              end else if (sseq_q[0] != want) begin
                st_q <= pjrb_pkg::ST_OOS; ov_q <= 1'b1;
              end else begin
                st_q <= pjrb_pkg::ST_DELIVERED;
                ol_q <= slen_q[0];
                oh_q <= shdl_q[0];
                for (int i = 0; i < CAPACITY - 1; i++) begin
                  sseq_q[i] <= sseq_q[i+1];
                  slen_q[i] <= slen_q[i+1];
                  shdl_q[i] <= shdl_q[i+1];
                end
                cnt_q <= cnt_q - CW'(1);
                ov_q <= 1'b1;
              end
            end
          end
        end
        S_WALK: begin
          // one held entry compared per cycle, tail toward head
          if (k_q == '0) begin
            state_q <= S_SHIFT;
          end else if (cur_q.seq == held) begin
            st_q <= pjrb_pkg::ST_DUP; ov_q <= 1'b1;
            state_q <= S_IDLE;
          end else if (cur_q.seq >= held + 16'd1) begin
            state_q <= S_SHIFT;
          end else begin
            k_q <= km1;
          end
        end
        S_SHIFT: begin
          // open a hole at k_q in one parallel move
          for (int i = 1; i < CAPACITY; i++) begin
            if (CW'(i) > k_q && CW'(i) <= cnt_q) begin
              sseq_q[i] <= sseq_q[i-1];
              slen_q[i] <= slen_q[i-1];
              shdl_q[i] <= shdl_q[i-1];
            end
          end
          sseq_q[k_q[IW-1:0]] <= cur_q.seq;
          slen_q[k_q[IW-1:0]] <= cur_q.length;
          shdl_q[k_q[IW-1:0]] <= cur_q.handle;
          cnt_q <= cnt_q + CW'(1);
          st_q <= pjrb_pkg::ST_ADDED;
          ov_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/packet_jitter_reorder_buffer_core.sv -----
// Top level: reorder buffer for sequence-numbered packets.
// channel | dir | fields (tdata low bit up)
// s_axis  | in  | tdata: cmd[1:0] seq[17:2] length[33:18] payload_handle[65:34]
// m_axis  | out | tdata: status[2:0] length_out[18:3] handle_out[50:19] fill_count[54:51]
// Get, and a full or late add, is decided in the idle state; other adds walk the held slots serially, then shift.
// One item is in the back end at a time; a two-entry queue takes items meanwhile.
// Reset clears count and sets the expected index to 1; slot contents are not reset.
// A stalled result holds the back end but the queue keeps accepting until its two entries are full.
module packet_jitter_reorder_buffer_core #(
  parameter int unsigned CAPACITY = pjrb_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // cmd, seq, length, payload_handle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // status, length_out, handle_out, fill_count
);
  pjrb_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  logic [2:0] status;
  logic [15:0] len;
  logic [31:0] hdl;
  logic [3:0] fill;

  assign in_cmd.cmd = s_axis_tdata[1:0];
  assign in_cmd.seq = s_axis_tdata[17:2];
  assign in_cmd.length = s_axis_tdata[33:18];
  assign in_cmd.handle = s_axis_tdata[65:34];

  pjrb_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  pjrb_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_o(status), .length_o(len), .handle_o(hdl), .fill_o(fill)
  );

  assign m_axis_tdata = {1'b0, fill, hdl, len, status};
endmodule

// ----- tb/pjrb_checker.sv -----
// Checker: predicts reorder buffer results from accepted commands and compares them.
module pjrb_checker #(
  parameter int unsigned CAPACITY = pjrb_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // cmd, seq, length, payload_handle
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,  // status, length_out, handle_out, fill_count
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  fill;
    logic [31:0] handle;
    logic [15:0] len;
    logic [2:0]  status;
  } result_t;

  logic [15:0] buf_seq [CAPACITY];
  logic [15:0] buf_len [CAPACITY];
  logic [31:0] buf_hdl [CAPACITY];
  int unsigned held;
  logic [15:0] next_idx;
  result_t     result_q [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o = result_q.size();

  function automatic logic [2:0] insert_pkt(logic [15:0] s, logic [15:0] l, logic [31:0] h);
    int unsigned pos;
    int unsigned k;
    logic [15:0] nxt;
    pos = 0;
    if (held >= CAPACITY) return pjrb_pkg::ST_FULL;
    if (s < next_idx && (17'(next_idx) - 17'(s)) <= pjrb_pkg::LATE_WINDOW)
      return pjrb_pkg::ST_LATE;
    for (k = held; k > 0; k--) begin
      if (s == buf_seq[k-1]) return pjrb_pkg::ST_DUP;
      nxt = buf_seq[k-1] + 16'd1;
      if (s >= nxt) begin
        pos = k;
        break;
      end
    end
    for (k = held; k > pos; k--) begin
      buf_seq[k] = buf_seq[k-1];
      buf_len[k] = buf_len[k-1];
      buf_hdl[k] = buf_hdl[k-1];
    end
    buf_seq[pos] = s;
    buf_len[pos] = l;
    buf_hdl[pos] = h;
    held++;
    return pjrb_pkg::ST_ADDED;
  endfunction

  function automatic result_t apply_cmd(logic [71:0] d);
    result_t r;
    logic [15:0] want;
    r = '0;
    if (d[1:0] == pjrb_pkg::CMD_ADD) begin
      r.status = insert_pkt(d[17:2], d[33:18], d[65:34]);
    end else begin
      if (d[1:0] == pjrb_pkg::CMD_SET_GET) next_idx = d[17:2];
      want = next_idx;
      next_idx = next_idx + 16'd1;
      if (held == 0) r.status = pjrb_pkg::ST_EMPTY;
      else if (buf_seq[0] != want) r.status = pjrb_pkg::ST_OOS;
      else begin
        r.status = pjrb_pkg::ST_DELIVERED;
        r.len = buf_len[0];
        r.handle = buf_hdl[0];
        for (int unsigned k = 1; k < held; k++) begin
          buf_seq[k-1] = buf_seq[k];
          buf_len[k-1] = buf_len[k];
          buf_hdl[k-1] = buf_hdl[k];
        end
        held--;
      end
    end
    r.fill = 4'(held);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t exp_r;
    if (!rst_ni) begin
      held = 0;
      next_idx = pjrb_pkg::EXP_RESET;
      fails = 0;
      result_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) result_q.push_back(apply_cmd(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[54:0];
        if (result_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          exp_r = result_q.pop_front();
          if (got.status != exp_r.status || got.len != exp_r.len ||
              got.handle != exp_r.handle || got.fill != exp_r.fill) begin
            fails++;
            $display({"%0t: mismatch expected st=%0d len=%h hdl=%h fill=%0d",
                      " actual st=%0d len=%h hdl=%h fill=%0d"},
                     $time, exp_r.status, exp_r.len, exp_r.handle, exp_r.fill,
                     got.status, got.len, got.handle, got.fill);
          end
        end
      end
    end
  end
endmodule

// ----- tb/testbench.sv -----
// Testbench top: stimulus, flow control and verdict for the reorder buffer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // cmd, seq, length, payload_handle
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // status, length_out, handle_out, fill_count
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          long_hold = 1'b0;
  logic [15:0] base_seq = 16'd1;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  packet_jitter_reorder_buffer_core DUT (.*);

  pjrb_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, quiet stretches, one or more long hold-offs
  initial begin
    int mode;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send(logic [1:0] c, logic [15:0] s, logic [15:0] l, logic [31:0] h);
    s_axis_tdata <= {6'd0, h, l, s, c};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic rand_item();
    int unsigned r;
    logic [15:0] s;
    r = $urandom_range(0, 99);
    s = base_seq + 16'($urandom_range(0, 9));
    if (r < 5) s = 16'($urandom);
    if (r < 55) send(pjrb_pkg::CMD_ADD, s, 16'($urandom), $urandom);
    else if (r < 90) begin
      send(($urandom_range(0, 1) != 0) ? pjrb_pkg::CMD_GET : pjrb_pkg::CMD_GET_ALT,
           16'd0, 16'($urandom), $urandom);
    end else if (r < 96) begin
      base_seq = 16'($urandom);
      if ($urandom_range(0, 1)) base_seq = 16'hfff8;
      send(pjrb_pkg::CMD_SET_GET, base_seq, 16'($urandom), $urandom);
      base_seq = base_seq + 16'd1;
    end else send(pjrb_pkg::CMD_GET_ALT, 16'($urandom), 16'($urandom), $urandom);
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty get, set, sorted inserts, duplicate, late, full, wrap, OOS
    send(pjrb_pkg::CMD_GET, 16'd0, 16'd0, 32'd0);
    send(pjrb_pkg::CMD_SET_GET, 16'd10, 16'hffff, 32'hffffffff);
    send(pjrb_pkg::CMD_ADD, 16'd13, 16'hffff, 32'hffffffff);
    send(pjrb_pkg::CMD_ADD, 16'd11, 16'h1234, 32'h0);
    send(pjrb_pkg::CMD_ADD, 16'd12, 16'h0, 32'h5a5a5a5a);
    send(pjrb_pkg::CMD_ADD, 16'd12, 16'h1, 32'h1);
    send(pjrb_pkg::CMD_ADD, 16'd5, 16'h1, 32'h1);
    send(pjrb_pkg::CMD_ADD, 16'hffff, 16'h2, 32'h2);
    send(pjrb_pkg::CMD_ADD, 16'd0, 16'h3, 32'h3);
    send(pjrb_pkg::CMD_ADD, 16'd20, 16'h4, 32'h4);
    send(pjrb_pkg::CMD_ADD, 16'd21, 16'h5, 32'h5);
    send(pjrb_pkg::CMD_ADD, 16'd22, 16'h6, 32'h6);
    send(pjrb_pkg::CMD_ADD, 16'd23, 16'h7, 32'h7);
    send(pjrb_pkg::CMD_ADD, 16'd24, 16'h8, 32'h8);
    send(pjrb_pkg::CMD_GET, 16'd0, 16'd0, 32'd0);
    send(pjrb_pkg::CMD_GET_ALT, 16'd0, 16'd0, 32'd0);
    send(pjrb_pkg::CMD_GET, 16'd0, 16'd0, 32'd0);
    send(pjrb_pkg::CMD_SET_GET, 16'hffff, 16'd0, 32'd0);
    send(pjrb_pkg::CMD_SET_GET, 16'd0, 16'd0, 32'd0);
    send(pjrb_pkg::CMD_SET_GET, 16'd13, 16'd0, 32'd0);
    send(pjrb_pkg::CMD_SET_GET, 16'd20, 16'd0, 32'd0);
    drain();
    base_seq = 16'd21;
    n = 0;
    while (n < 550) begin
      repeat ($urandom_range(1, 20)) begin
        rand_item();
        n++;
      end
      if (n > 150 && n < 171) long_hold = 1'b1;
      if (n > 350 && n < 371) drain();
      else gap();
    end
    drain();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
sv/pjrb_pkg.sv
sv/pjrb_front.sv
sv/pjrb_back.sv
sv/packet_jitter_reorder_buffer_core.sv
tb/pjrb_checker.sv
tb/testbench.sv
